FILE: design/skri_pkg.sv
// ----------------------------------------------------------------------------
// skri_pkg: shared types and constants of the sorted key range index
// Key encoding, request classification, predicate plans and state codes.
// ----------------------------------------------------------------------------
package skri_pkg;

   localparam int TABLE_DEPTH = 1024;
   localparam int BATCH_SIZE  = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int POS_W       = $clog2(TABLE_DEPTH + 1);
   localparam int BATCH_W     = $clog2(BATCH_SIZE + 1);
   localparam int KEY_W       = 64;
   localparam int ROW_W       = 63;
   localparam int ENTRY_W     = KEY_W + ROW_W;
   localparam int FIFO_DEPTH  = 2;

   localparam logic [1:0] OP_INSERT = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_FETCH  = 2'd2;

   localparam logic [2:0] KT_INT8   = 3'd0;
   localparam logic [2:0] KT_INT16  = 3'd1;
   localparam logic [2:0] KT_INT32  = 3'd2;
   localparam logic [2:0] KT_INT64  = 3'd3;
   localparam logic [2:0] KT_DOUBLE = 3'd4;

   localparam logic [3:0] PRED_EQ    = 4'd0;
   localparam logic [3:0] PRED_GT    = 4'd1;
   localparam logic [3:0] PRED_GE    = 4'd2;
   localparam logic [3:0] PRED_LT    = 4'd3;
   localparam logic [3:0] PRED_LE    = 4'd4;
   localparam logic [3:0] PRED_GT_LT = 4'd5;
   localparam logic [3:0] PRED_GT_LE = 4'd6;
   localparam logic [3:0] PRED_GE_LT = 4'd7;
   localparam logic [3:0] PRED_GE_LE = 4'd8;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_NONE = 2'd2;
   localparam logic [1:0] ST_BAD  = 2'd3;

   localparam logic [63:0] SIGN64 = 64'h8000_0000_0000_0000;

   typedef struct packed {
      logic [1:0]        op;
      logic signed [63:0] low_key;
      logic signed [63:0] high_key;
      logic [62:0]       row_ident;
      logic [3:0]        pred;
   } req_type;

   typedef struct packed {
      logic [62:0] row_id_out;
      logic [10:0] start_pos;
      logic [10:0] end_pos;
      logic [1:0]  status;
      logic        last;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_INSERT,
      CMD_QUERY,
      CMD_FETCH,
      CMD_BAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type      kind;
      logic [KEY_W-1:0]  lo_key;
      logic [KEY_W-1:0]  hi_key;
      logic [ROW_W-1:0]  row;
      logic [3:0]        pred;
   } cmd_type;

   typedef struct packed {
      logic             ok;
      logic [KEY_W-1:0] enc;
   } enc_type;

   typedef struct packed {
      logic need_s;
      logic s_strict;
      logic need_e;
      logic e_hi;
      logic e_strict;
   } plan_type;

   typedef enum logic [3:0] {
      BK_IDLE,
      BK_SRCH_RD,
      BK_SRCH_CMP,
      BK_SHIFT_RD,
      BK_SHIFT_WR,
      BK_FETCH_RD,
      BK_FETCH_EMIT,
      BK_RESP
   } back_state_type;

   typedef struct packed {
      logic [1:0] fill;
   } front_stat_type;

   typedef struct packed {
      logic             busy;
      logic [POS_W-1:0] count;
   } back_stat_type;

   // order-preserving transform: unsigned compare of the result orders keys
   function automatic enc_type encode_key(input logic [63:0] raw, input logic [2:0] kt);
      enc_type     r;
      logic [63:0] v;
      r.ok  = 1'b1;
      r.enc = '0;
      v     = raw;
      case (kt)
         KT_INT8:   r.enc = {{56{raw[7]}}, raw[7:0]} ^ SIGN64;
         KT_INT16:  r.enc = {{48{raw[15]}}, raw[15:0]} ^ SIGN64;
         KT_INT32:  r.enc = {{32{raw[31]}}, raw[31:0]} ^ SIGN64;
         KT_INT64:  r.enc = raw ^ SIGN64;
         KT_DOUBLE: begin
            if (raw[62:52] == 11'h7FF && raw[51:0] != 52'd0) begin
               r.ok = 1'b0;
            end
            if (raw == SIGN64) begin
               v = '0;
            end
            r.enc = v[63] ? ~v : (v | SIGN64);
         end
         default:   r.ok = 1'b0;
      endcase
      return r;
   endfunction

   // which bound searches a predicate needs
   function automatic plan_type pred_plan(input logic [3:0] pred);
      plan_type p;
      p = '{need_s: 1'b1, s_strict: 1'b0, need_e: 1'b1, e_hi: 1'b0, e_strict: 1'b1};
      case (pred)
         PRED_EQ:    p = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
         PRED_GT:    p = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b0};
         PRED_GE:    p = '{1'b1, 1'b0, 1'b0, 1'b0, 1'b0};
         PRED_LT:    p = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0};
         PRED_LE:    p = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b1};
         PRED_GT_LT: p = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
         PRED_GT_LE: p = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1};
         PRED_GE_LT: p = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
         PRED_GE_LE: p = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
         default:    p = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
      endcase
      return p;
   endfunction

endpackage

FILE: design/skri_ram.sv
// ----------------------------------------------------------------------------
// skri_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module skri_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

FILE: design/skri_front.sv
// ----------------------------------------------------------------------------
// skri_front: request intake
// Encodes keys, classifies each request and queues it for the back end.
// ----------------------------------------------------------------------------
module skri_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [2:0]              key_type,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  skri_pkg::req_type       req_data,
   output logic                    cmd_valid,
   input  logic                    cmd_pop,
   output skri_pkg::cmd_type       cmd_data,
   output skri_pkg::front_stat_type stat
);

   skri_pkg::cmd_type  q_ff [skri_pkg::FIFO_DEPTH];
   logic               wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0]         fill_ff, fill_in;
   skri_pkg::cmd_type  cls;
   skri_pkg::enc_type  enc_lo, enc_hi;
   logic               push, pop;

   always_comb begin
      enc_lo   = skri_pkg::encode_key(req_data.low_key, key_type);
      enc_hi   = skri_pkg::encode_key(req_data.high_key, key_type);
      cls.lo_key = enc_lo.enc;
      cls.hi_key = enc_hi.enc;
      cls.row    = req_data.row_ident;
      cls.pred   = req_data.pred;
      cls.kind   = skri_pkg::CMD_BAD;
      case (req_data.op)
         skri_pkg::OP_INSERT: begin
            if (enc_lo.ok) begin
               cls.kind = skri_pkg::CMD_INSERT;
            end
         end
         skri_pkg::OP_QUERY: begin
            if (!(req_data.pred inside {[4'd9:4'd15]}) && enc_lo.ok &&
                (req_data.pred < skri_pkg::PRED_GT_LT || enc_hi.ok)) begin
               cls.kind = skri_pkg::CMD_QUERY;
            end
         end
         skri_pkg::OP_FETCH: cls.kind = skri_pkg::CMD_FETCH;
         default:            cls.kind = skri_pkg::CMD_BAD;
      endcase
   end

   assign req_ready = (fill_ff != 2'(skri_pkg::FIFO_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (fill_ff != 2'd0);
   assign pop       = cmd_pop && cmd_valid;
   assign cmd_data  = q_ff[rp_ff];
   assign stat.fill = fill_ff;

   always_comb begin
      wp_in   = push ? ~wp_ff : wp_ff;
      rp_in   = pop ? ~rp_ff : rp_ff;
      fill_in = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff   <= 1'b0;
         rp_ff   <= 1'b0;
         fill_ff <= 2'd0;
      end else begin
         wp_ff   <= wp_in;
         rp_ff   <= rp_in;
         fill_ff <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

endmodule

FILE: design/skri_back.sv
// ----------------------------------------------------------------------------
// skri_back: table sequencer
// Runs bound searches, insert shifts and fetch scans over the entry RAM.
// ----------------------------------------------------------------------------
module skri_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    cmd_valid,
   output logic                    cmd_pop,
   input  skri_pkg::cmd_type       cmd_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output skri_pkg::rsp_type       rsp_data,
   output skri_pkg::back_stat_type stat
);

   localparam int PW = skri_pkg::POS_W;
   localparam int IW = skri_pkg::IDX_W;
   localparam int BW = skri_pkg::BATCH_W;

   skri_pkg::back_state_type state_ff, state_in;
   skri_pkg::cmd_type        cur_ff, cur_in;
   logic [PW-1:0]            count_ff, count_in, cursor_ff, cursor_in, send_ff, send_in;
   logic [PW-1:0]            lo_ff, lo_in, hi_ff, hi_in, s_ff, s_in, idx_ff, idx_in;
   logic [IW-1:0]            mid_ff, mid_in;
   logic [63:0]              key_ff, key_in;
   logic                     strict_ff, strict_in, phase_ff, phase_in;
   logic [BW-1:0]            n_ff, n_in;
   skri_pkg::rsp_type        res_ff, res_in, rsp_ff, rsp_in;
   logic                     rsp_valid_ff, rsp_valid_in;

   logic                         ram_we, ram_re;
   logic [IW-1:0]                ram_waddr, ram_raddr;
   logic [skri_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

   skri_pkg::plan_type pl;
   logic               out_free, go_right, last_row;
   logic [PW-1:0]      mid_full, fin_s, fin_e, end_eff;
   logic [63:0]        ekey;

   skri_ram #(.WIDTH(skri_pkg::ENTRY_W), .DEPTH(skri_pkg::TABLE_DEPTH)) u_ram (
      .clock(clock), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
      .re(ram_re), .raddr(ram_raddr), .rdata(ram_rdata)
   );

   assign out_free   = !rsp_valid_ff || rsp_ready;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign stat.busy  = (state_ff != skri_pkg::BK_IDLE);
   assign stat.count = count_ff;

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      count_in     = count_ff;
      cursor_in    = cursor_ff;
      send_in      = send_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      s_in         = s_ff;
      idx_in       = idx_ff;
      mid_in       = mid_ff;
      key_in       = key_ff;
      strict_in    = strict_ff;
      phase_in     = phase_ff;
      n_in         = n_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      cmd_pop      = 1'b0;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      ram_waddr    = idx_ff[IW-1:0];
      ram_raddr    = mid_ff;
      ram_wdata    = ram_rdata;
      pl           = skri_pkg::pred_plan(cur_ff.pred);
      ekey         = pl.e_hi ? cur_ff.hi_key : cur_ff.lo_key;
      mid_full     = lo_ff + ((hi_ff - lo_ff) >> 1);
      go_right     = strict_ff ? (ram_rdata[skri_pkg::ENTRY_W-1:skri_pkg::ROW_W] <= key_ff)
                               : (ram_rdata[skri_pkg::ENTRY_W-1:skri_pkg::ROW_W] < key_ff);
      last_row     = ((cursor_ff + PW'(1)) >= send_ff) || (n_ff == BW'(skri_pkg::BATCH_SIZE - 1));
      fin_s        = '0;
      fin_e        = '0;
      end_eff      = (send_ff > count_ff) ? count_ff : send_ff;

      case (state_ff)
         skri_pkg::BK_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               cur_in  = cmd_data;
               pl      = skri_pkg::pred_plan(cmd_data.pred);
               res_in  = '{row_id_out: '0, start_pos: '0, end_pos: '0,
                           status: skri_pkg::ST_BAD, last: 1'b1};
               state_in = skri_pkg::BK_RESP;
               lo_in    = '0;
               hi_in    = count_ff;
               case (cmd_data.kind)
                  skri_pkg::CMD_INSERT: begin
                     if (count_ff >= PW'(skri_pkg::TABLE_DEPTH)) begin
                        res_in.status  = skri_pkg::ST_FULL;
                        res_in.end_pos = count_ff;
                     end else begin
                        key_in    = cmd_data.lo_key;
                        strict_in = 1'b1;
                        state_in  = skri_pkg::BK_SRCH_RD;
                     end
                  end
                  skri_pkg::CMD_QUERY: begin
                     state_in = skri_pkg::BK_SRCH_RD;
                     if (pl.need_s) begin
                        key_in    = cmd_data.lo_key;
                        strict_in = pl.s_strict;
                        phase_in  = 1'b0;
                     end else begin
                        s_in      = '0;
                        key_in    = pl.e_hi ? cmd_data.hi_key : cmd_data.lo_key;
                        strict_in = pl.e_strict;
                        phase_in  = 1'b1;
                     end
                  end
                  skri_pkg::CMD_FETCH: begin
                     send_in = end_eff;
                     n_in    = '0;
                     if (cursor_ff >= end_eff) begin
                        res_in.status = skri_pkg::ST_NONE;
                     end else begin
                        state_in = skri_pkg::BK_FETCH_RD;
                     end
                  end
                  default: state_in = skri_pkg::BK_RESP;
               endcase
            end
         end
         skri_pkg::BK_SRCH_RD: begin
            if (lo_ff < hi_ff) begin
               mid_in    = mid_full[IW-1:0];
               ram_re    = 1'b1;
               ram_raddr = mid_full[IW-1:0];
               state_in  = skri_pkg::BK_SRCH_CMP;
            end else if (cur_ff.kind == skri_pkg::CMD_INSERT) begin
               s_in     = lo_ff;
               idx_in   = count_ff;
               state_in = skri_pkg::BK_SHIFT_RD;
            end else if (!phase_ff && pl.need_e) begin
               s_in      = lo_ff;
               lo_in     = '0;
               hi_in     = count_ff;
               key_in    = ekey;
               strict_in = pl.e_strict;
               phase_in  = 1'b1;
            end else begin
               fin_s     = phase_ff ? s_ff : lo_ff;
               fin_e     = phase_ff ? lo_ff : count_ff;
               fin_e     = (fin_e < fin_s) ? fin_s : fin_e;
               cursor_in = fin_s;
               send_in   = fin_e;
               res_in    = '{row_id_out: '0, start_pos: fin_s, end_pos: fin_e,
                             status: skri_pkg::ST_OK, last: 1'b1};
               state_in  = skri_pkg::BK_RESP;
            end
         end
         skri_pkg::BK_SRCH_CMP: begin
            if (go_right) begin
               lo_in = {1'b0, mid_ff} + PW'(1);
            end else begin
               hi_in = {1'b0, mid_ff};
            end
            state_in = skri_pkg::BK_SRCH_RD;
         end
         skri_pkg::BK_SHIFT_RD: begin
            if (idx_ff > s_ff) begin
               ram_re    = 1'b1;
               ram_raddr = IW'(idx_ff - PW'(1));
               state_in  = skri_pkg::BK_SHIFT_WR;
            end else begin
               ram_we    = 1'b1;
               ram_waddr = s_ff[IW-1:0];
               ram_wdata = {cur_ff.lo_key, cur_ff.row};
               count_in  = count_ff + PW'(1);
               res_in    = '{row_id_out: '0, start_pos: s_ff, end_pos: count_ff + PW'(1),
                             status: skri_pkg::ST_OK, last: 1'b1};
               state_in  = skri_pkg::BK_RESP;
            end
         end
         skri_pkg::BK_SHIFT_WR: begin
            // entry idx-1 moves up one place
            ram_we    = 1'b1;
            ram_waddr = idx_ff[IW-1:0];
            idx_in    = idx_ff - PW'(1);
            state_in  = skri_pkg::BK_SHIFT_RD;
         end
         skri_pkg::BK_FETCH_RD: begin
            ram_re    = 1'b1;
            ram_raddr = cursor_ff[IW-1:0];
            state_in  = skri_pkg::BK_FETCH_EMIT;
         end
         skri_pkg::BK_FETCH_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '{row_id_out: ram_rdata[skri_pkg::ROW_W-1:0],
                                start_pos: cursor_ff, end_pos: send_ff,
                                status: skri_pkg::ST_OK, last: last_row};
               cursor_in    = cursor_ff + PW'(1);
               n_in         = n_ff + BW'(1);
               state_in     = last_row ? skri_pkg::BK_IDLE : skri_pkg::BK_FETCH_RD;
            end
         end
         skri_pkg::BK_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = skri_pkg::BK_IDLE;
            end
         end
         default: state_in = skri_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= skri_pkg::BK_IDLE;
         count_ff     <= '0;
         cursor_ff    <= '0;
         send_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cursor_ff    <= cursor_in;
         send_ff      <= send_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      s_ff      <= s_in;
      idx_ff    <= idx_in;
      mid_ff    <= mid_in;
      key_ff    <= key_in;
      strict_ff <= strict_in;
      phase_ff  <= phase_in;
      n_ff      <= n_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

endmodule

FILE: design/sorted_key_range_index_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_range_index_unit: sorted (key, row id) table with range scans
// Insert, range query and batched fetch over a key-sorted table.
// ----------------------------------------------------------------------------
// Usage: requests enter on req_valid/req_ready; results leave on
// rsp_valid/rsp_ready, one per insert or query, up to 16 per fetch, the final
// one of each request flagged by last. key_type is set through the APB port
// (address 0) only while idle, a rule for the user that the block does not
// enforce. Each binary search step reads the middle entry and compares it; a
// query runs two searches at most, an insert one search and then a read and a
// write per entry moved up, a fetch a read and an emit per row. Everything is
// bound by the single read port of the entry RAM. A two-entry request queue
// lets the intake keep taking requests while the sequencer works.
// Reset empties the table and the scan and sets key_type to int32; the RAM
// contents are not cleared. When the receiver stalls, the result register
// holds its result and the sequencer waits; the queue still fills.
// ----------------------------------------------------------------------------
module sorted_key_range_index_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  skri_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output skri_pkg::rsp_type rsp_data,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [2:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   logic [2:0]                key_type_ff, key_type_in;
   logic                      cmd_valid, cmd_pop;
   skri_pkg::cmd_type         cmd_data;
   skri_pkg::front_stat_type  fstat;
   skri_pkg::back_stat_type   bstat;

   assign pready = 1'b1;
   assign prdata = (paddr[2] == 1'b0) ? {29'd0, key_type_ff} : 32'd0;

   always_comb begin
      key_type_in = key_type_ff;
      if (psel && penable && pwrite && paddr[2] == 1'b0) begin
         key_type_in = pwdata[2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_type_ff <= skri_pkg::KT_INT32;
      end else begin
         key_type_ff <= key_type_in;
      end
   end

   skri_front u_front (
      .clock(clock), .reset(reset), .key_type(key_type_ff),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd_data(cmd_data), .stat(fstat)
   );

   skri_back u_back (
      .clock(clock), .reset(reset),
      .cmd_valid(cmd_valid), .cmd_pop(cmd_pop), .cmd_data(cmd_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data), .stat(bstat)
   );

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      bstat.count <= skri_pkg::POS_W'(skri_pkg::TABLE_DEPTH))
      else $error("entry count beyond table depth");

   a_fill_range: assert property (@(posedge clock) disable iff (reset)
      fstat.fill <= 2'(skri_pkg::FIFO_DEPTH))
      else $error("request queue overfilled");

   a_full_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status != skri_pkg::ST_OK |-> rsp_data.last)
      else $error("error result not marked last");

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !bstat.busy && cmd_valid)
      else $error("request taken while sequencer busy");

endmodule
